// ===== rtl/tctm_pkg.sv =====
// ----------------------------------------------------------------------------
// tctm_pkg
// Shared types and constants for the three-channel timer module: field
// widths, register offsets, action codes, sequencer states and the
// request and response structs of the remainder unit.
// ----------------------------------------------------------------------------
package tctm_pkg;

  // Number of tick_cycles bits that count.
  localparam int TickBits = 8;
  localparam int TickFieldW = 8;
  localparam int CycW = (TickBits < TickFieldW) ? TickBits : TickFieldW;

  localparam int CntW = 16;
  localparam int PerW = CntW + 1;
  localparam int NumTimers = 3;
  localparam int IdxW = 2;
  localparam int StepW = $clog2(CycW + 1);

  // Action codes.
  localparam logic [1:0] ActTick  = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActWrite = 2'd2;

  // Register offsets.
  localparam logic [2:0] OffStatus = 3'd0;
  localparam logic [2:0] OffCtrl2  = 3'd1;

  // Control and status bits.
  localparam int CtrlHoldBit = 0;
  localparam int CtrlSelBit  = 0;
  localparam int CtrlIrqEnBit = 6;
  localparam int StatIrqBit  = 7;

  localparam logic [CntW-1:0] CntAllOnes = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REM,
    ST_FINISH
  } tctm_state_e;

  typedef struct packed {
    logic            start;
    logic [CycW-1:0] dividend;
    logic [PerW-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic            done;
    logic [CycW-1:0] rem;
  } rem_rsp_t;

endpackage

// ===== rtl/tctm_rem_unit.sv =====
// ----------------------------------------------------------------------------
// tctm_rem_unit
// Iterative restoring remainder unit. One dividend bit is shifted in and
// one trial subtraction is made per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module tctm_rem_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tctm_pkg::rem_req_t req_i,
  output tctm_pkg::rem_rsp_t rsp_o
);
  import tctm_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CycW-1:0]  dvd_q, dvd_d;
  logic [CycW-1:0]  rem_q, rem_d;
  logic [PerW-1:0]  div_q, div_d;

  logic [CycW:0]    trial;
  logic [PerW-1:0]  trial_ext;
  logic [PerW-1:0]  diff;

  assign trial     = {rem_q, dvd_q[CycW-1]};
  assign trial_ext = PerW'(trial);
  assign diff      = trial_ext - div_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = StepW'(CycW);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      // The partial remainder never exceeds the dividend, so CycW bits hold it.
      if (trial_ext >= div_q) begin
        rem_d = diff[CycW-1:0];
      end else begin
        rem_d = trial[CycW-1:0];
      end
      dvd_d  = dvd_q << 1;
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/three_channel_timer_module_core.sv =====
// ----------------------------------------------------------------------------
// three_channel_timer_module_core
// Three 16-bit down-counters with reload latches, three control registers
// and a status byte, driven by tick, register read and register write
// transactions. Each transaction returns one result transaction.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+----------------------------
//   in      | input     | in_valid_i / in_stall_o | action, reg_offset,
//           |           |                        | write_data, tick_cycles
//   out     | output    | out_valid_o / out_stall_i | read_data, irq_pending
//
// A register read or write is applied at the edge that accepts it; its result
// then goes from the finish state into the output register.
// A tick walks the three timers one after another: each timer is compared in
// the check state and, when it wraps, has its leftover count reduced in the
// shared remainder unit, a bit-serial loop, before the next timer is checked.
// The block takes one transaction at a time; in_stall_o is high while it
// works. Reset loads the counters and latches with all ones and clears the
// control and status registers. A stalled result waits in the output
// register and holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module three_channel_timer_module_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [2:0] reg_offset_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] tick_cycles_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       irq_pending_o
);
  import tctm_pkg::*;

  // Sequencer state.
  tctm_state_e     state_q, state_d;
  logic [IdxW-1:0] tmr_q, tmr_d;
  logic [CycW-1:0] cyc_q, cyc_d;
  logic [7:0]      rd_q, rd_d;

  // Architectural state. The counter and latch arrays have a single
  // access index that both reads and writes use.
  logic [CntW-1:0] cnt_q [NumTimers];
  logic [CntW-1:0] lat_q [NumTimers];
  logic [7:0]      ctrl1_q, ctrl1_d;
  logic [7:0]      ctrl2_q, ctrl2_d;
  logic [7:0]      ctrl3_q, ctrl3_d;
  logic [7:0]      stat_q, stat_d;

  logic            cnt_we, lat_we;
  logic [CntW-1:0] cnt_wdata, lat_wdata;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_data_q, out_data_d;
  logic            out_irq_q, out_irq_d;

  logic            in_accept;
  logic [IdxW-1:0] acc_idx;
  logic [CntW-1:0] cnt_rd, lat_rd;
  logic [CntW-1:0] top;
  logic [PerW-1:0] period;
  logic [CntW-1:0] cyc_ext;
  logic [CntW-1:0] left_full;
  logic [7:0]      ctrl_sel;
  logic            irq;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // While idle the array index comes from the register offset; while a
  // tick runs it comes from the timer being worked on.
  always_comb begin
    if (state_q == ST_IDLE) begin
      if (reg_offset_i[2:1] != 2'd0) begin
        acc_idx = reg_offset_i[2:1] - IdxW'(1);
      end else begin
        acc_idx = '0;
      end
    end else begin
      acc_idx = tmr_q;
    end
  end

  assign cnt_rd  = cnt_q[acc_idx];
  assign lat_rd  = lat_q[acc_idx];
  // A zero latch acts as a full period of 65536 counts.
  assign top     = (lat_rd == '0) ? CntAllOnes : lat_rd;
  assign period  = PerW'(top) + PerW'(1);
  assign cyc_ext = CntW'(cyc_q);
  assign left_full = cyc_ext - cnt_rd - CntW'(1);

  always_comb begin
    case (tmr_q)
      2'd0:    ctrl_sel = ctrl1_q;
      2'd1:    ctrl_sel = ctrl2_q;
      default: ctrl_sel = ctrl3_q;
    endcase
  end

  // A timer asks for an interrupt when its flag and its enable are both set.
  assign irq = |(stat_q[NumTimers-1:0] &
                 {ctrl3_q[CtrlIrqEnBit], ctrl2_q[CtrlIrqEnBit], ctrl1_q[CtrlIrqEnBit]});

  always_comb begin
    state_d     = state_q;
    tmr_d       = tmr_q;
    cyc_d       = cyc_q;
    rd_d        = rd_q;
    ctrl1_d     = ctrl1_q;
    ctrl2_d     = ctrl2_q;
    ctrl3_d     = ctrl3_q;
    stat_d      = stat_q;
    cnt_we      = 1'b0;
    lat_we      = 1'b0;
    cnt_wdata   = cnt_rd;
    lat_wdata   = lat_rd;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    out_irq_d   = out_irq_q;
    rem_req.start    = 1'b0;
    rem_req.dividend = left_full[CycW-1:0];
    rem_req.divisor  = period;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          rd_d    = '0;
          state_d = ST_FINISH;
          if (action_i == ActTick) begin
            cyc_d = tick_cycles_i[CycW-1:0];
            tmr_d = '0;
            // A held or empty tick changes nothing.
            if (!ctrl1_q[CtrlHoldBit] && (tick_cycles_i[CycW-1:0] != '0)) begin
              state_d = ST_CHECK;
            end
          end else if (action_i == ActRead) begin
            if (reg_offset_i == OffStatus) begin
              rd_d   = stat_q;
              stat_d = '0;
            end else if (reg_offset_i == OffCtrl2) begin
              rd_d = ctrl2_q;
            end else if (reg_offset_i[0]) begin
              rd_d = cnt_rd[7:0];
            end else begin
              rd_d = cnt_rd[15:8];
            end
          end else if (action_i == ActWrite) begin
            if (reg_offset_i == OffStatus) begin
              if (ctrl2_q[CtrlSelBit]) begin
                ctrl1_d = write_data_i;
              end else begin
                ctrl3_d = write_data_i;
              end
            end else if (reg_offset_i == OffCtrl2) begin
              ctrl2_d = write_data_i;
            end else if (reg_offset_i[0]) begin
              // The low byte completes the latch and loads the counter.
              lat_we    = 1'b1;
              lat_wdata = {lat_rd[15:8], write_data_i};
              cnt_we    = 1'b1;
              cnt_wdata = {lat_rd[15:8], write_data_i};
            end else begin
              lat_we    = 1'b1;
              lat_wdata = {write_data_i, lat_rd[7:0]};
            end
          end
        end
      end

      ST_CHECK: begin
        if (cyc_ext > cnt_rd) begin
          // Underflow: flag the timer and reduce the leftover cycles modulo
          // the reload period in the remainder unit.
          stat_d[tmr_q] = 1'b1;
          if (ctrl_sel[CtrlIrqEnBit]) begin
            stat_d[StatIrqBit] = 1'b1;
          end
          rem_req.start = 1'b1;
          state_d = ST_REM;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd - cyc_ext;
          if (tmr_q == IdxW'(NumTimers - 1)) begin
            state_d = ST_FINISH;
          end else begin
            tmr_d = tmr_q + IdxW'(1);
          end
        end
      end

      ST_REM: begin
        if (rem_rsp.done) begin
          cnt_we    = 1'b1;
          cnt_wdata = top - CntW'(rem_rsp.rem);
          if (tmr_q == IdxW'(NumTimers - 1)) begin
            state_d = ST_FINISH;
          end else begin
            tmr_d   = tmr_q + IdxW'(1);
            state_d = ST_CHECK;
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_q;
          out_irq_d   = irq;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  tctm_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tmr_q       <= '0;
      ctrl1_q     <= '0;
      ctrl2_q     <= '0;
      ctrl3_q     <= '0;
      stat_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumTimers; i++) begin
        cnt_q[i] <= CntAllOnes;
        lat_q[i] <= CntAllOnes;
      end
    end else begin
      state_q     <= state_d;
      tmr_q       <= tmr_d;
      ctrl1_q     <= ctrl1_d;
      ctrl2_q     <= ctrl2_d;
      ctrl3_q     <= ctrl3_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      if (cnt_we) begin
        cnt_q[acc_idx] <= cnt_wdata;
      end
      if (lat_we) begin
        lat_q[acc_idx] <= lat_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cyc_q      <= cyc_d;
    rd_q       <= rd_d;
    out_data_q <= out_data_d;
    out_irq_q  <= out_irq_d;
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_data_q;
  assign irq_pending_o = out_irq_q;

  // The remainder handed back is always below the period of its timer.
  a_rem_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REM && rem_rsp.done) |-> (PerW'(rem_rsp.rem) < period))
    else $error("remainder not below the reload period");

  // Reading the status register clears it.
  a_status_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && action_i == ActRead && reg_offset_i == OffStatus)
      |=> (stat_q == '0))
    else $error("status not cleared after read");

  // A tick with counting held goes straight to the result.
  a_hold_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && action_i == ActTick && ctrl1_q[CtrlHoldBit])
      |=> (state_q == ST_FINISH))
    else $error("held tick started counting");

  // The timer index never leaves the three timers.
  a_tmr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK || state_q == ST_REM) |-> (tmr_q != 2'd3))
    else $error("timer index out of range");

endmodule

// ===== tb/tctm_timer_checker.sv =====
// ----------------------------------------------------------------------------
// tctm_timer_checker
// Watches both channels of the three-channel timer module. It keeps its own
// copy of the counters, latches, control and status registers, works out
// the expected result of every accepted input transaction, and compares
// each accepted output transaction with the oldest expectation.
// ----------------------------------------------------------------------------
module tctm_timer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] action_i,
  input  logic [2:0] reg_offset_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] tick_cycles_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] read_data_i,
  input  logic       irq_pending_i,
  output int         err_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tctm_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pending;
  } timer_result_t;

  logic [CntW-1:0] counter_q [NumTimers];
  logic [CntW-1:0] latch_q [NumTimers];
  logic [7:0]      ctrl_q [NumTimers];
  logic [7:0]      status_q;

  timer_result_t   expected_results[$];
  int              mismatches;

  assign err_count_o = mismatches;

  // Counts every timer down unless counting is held; a wrap reloads from the latch once per period.
  task automatic count_timers(input int unsigned cycles);
    int unsigned cnt;
    int unsigned top;
    int unsigned left;
    int          t;
    if (ctrl_q[0][CtrlHoldBit]) return;
    for (t = 0; t < NumTimers; t++) begin
      cnt  = counter_q[t];
      top  = (latch_q[t] != '0) ? int'(latch_q[t]) : int'(CntAllOnes);
      left = cycles;
      if (left > cnt) begin
        left = left - cnt - 1;
        status_q[t] = 1'b1;
        if (ctrl_q[t][CtrlIrqEnBit]) status_q[StatIrqBit] = 1'b1;
        left = left % (top + 1);
        cnt  = top;
      end
      counter_q[t] = CntW'(cnt - left);
    end
  endtask

  function automatic logic irq_line();
    int t;
    for (t = 0; t < NumTimers; t++) begin
      if (status_q[t] && ctrl_q[t][CtrlIrqEnBit]) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic apply_transaction(input logic [1:0] act, input logic [2:0] off,
                                   input logic [7:0] wd, input logic [CycW-1:0] cyc,
                                   output timer_result_t res);
    int unsigned idx;
    res.read_data = '0;
    idx = (int'(off) >> 1) - 1;
    case (act)
      ActTick: count_timers(cyc);
      ActRead: begin
        if (off == OffStatus) begin
          res.read_data = status_q;
          status_q = '0;
        end else if (off == OffCtrl2) begin
          res.read_data = ctrl_q[1];
        end else begin
          res.read_data = off[0] ? counter_q[idx][7:0] : counter_q[idx][15:8];
        end
      end
      ActWrite: begin
        if (off == OffStatus) begin
          if (ctrl_q[1][CtrlSelBit]) ctrl_q[0] = wd;
          else ctrl_q[2] = wd;
        end else if (off == OffCtrl2) begin
          ctrl_q[1] = wd;
        end else if (!off[0]) begin
          latch_q[idx][15:8] = wd;
        end else begin
          latch_q[idx][7:0] = wd;
          counter_q[idx] = latch_q[idx];
        end
      end
      default: ;
    endcase
    res.irq_pending = irq_line();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t exp_res;
    timer_result_t new_res;
    if (!rst_ni) begin
      for (int t = 0; t < NumTimers; t++) begin
        counter_q[t] = CntAllOnes;
        latch_q[t]   = CntAllOnes;
        ctrl_q[t]    = '0;
      end
      status_q = '0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result read_data=%h irq_pending=%b", $time,
                   read_data_i, irq_pending_i);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (read_data_i !== exp_res.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time,
                     exp_res.read_data, read_data_i);
            mismatches++;
          end
          if (irq_pending_i !== exp_res.irq_pending) begin
            $display("%0t: irq_pending expected %b actual %b", $time,
                     exp_res.irq_pending, irq_pending_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_transaction(action_i, reg_offset_i, write_data_i, tick_cycles_i[CycW-1:0],
                          new_res);
        expected_results.push_back(new_res);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== tb/three_channel_timer_module_core_tb.sv =====
// ----------------------------------------------------------------------------
// three_channel_timer_module_core_tb
// Drives the timer block with a directed sequence of register accesses and
// ticks, then with a long random mix, under random idling on both channels
// and one long output hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module three_channel_timer_module_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tctm_pkg::*;

  // Action code that the block treats as a no-op, returning a zero read value.
  localparam logic [1:0] ActNone = 2'd3;

  // Timer latch byte offsets: even is MSB, odd is LSB.
  localparam logic [2:0] OffT1Msb = 3'd2;
  localparam logic [2:0] OffT1Lsb = 3'd3;
  localparam logic [2:0] OffT2Msb = 3'd4;
  localparam logic [2:0] OffT2Lsb = 3'd5;
  localparam logic [2:0] OffT3Msb = 3'd6;
  localparam logic [2:0] OffT3Lsb = 3'd7;

  localparam int RandomItems   = 1800;
  localparam int MaxIdle       = 17;
  // The long hold-off on the output channel, and the item count that starts it.
  localparam int HoldOffCycles = 400;
  localparam int HoldOffAfter  = 600;
  // The drain allows for the longest tick, with margin.
  localparam int DrainCycles   = 3 * (CycW + 2) + 10;
  // Idle-cycle limit: well above the hold-off plus the worst gap and tick.
  localparam int WatchdogLimit = 2500;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [1:0] action      = ActTick;
  logic [2:0] reg_offset  = OffStatus;
  logic [7:0] write_data  = '0;
  logic [7:0] tick_cycles = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] read_data;
  logic       irq_pending;

  int err_count;
  int pending;
  int sent_items  = 0;
  int idle_cycles = 0;
  // While set, neither side idles; the stimulus process toggles it in phases.
  bit no_idle     = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  three_channel_timer_module_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .reg_offset_i (reg_offset),
    .write_data_i (write_data),
    .tick_cycles_i(tick_cycles),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_o  (read_data),
    .irq_pending_o(irq_pending)
  );

  tctm_timer_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .action_i     (action),
    .reg_offset_i (reg_offset),
    .write_data_i (write_data),
    .tick_cycles_i(tick_cycles),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_i  (read_data),
    .irq_pending_i(irq_pending),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  // Offers one transaction. Inputs change only at falling edges, and valid
  // stays high across back-to-back transactions, so each edge carries at most
  // one assignment to it. The transaction is accepted at the first rising
  // edge where the block does not stall.
  task automatic send_item(input logic [1:0] act, input logic [2:0] off,
                           input logic [7:0] wd, input logic [7:0] tc);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    action      <= act;
    reg_offset  <= off;
    write_data  <= wd;
    tick_cycles <= tc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // One random transaction. Writes lean toward small latch high bytes so the
  // timers wrap often, and rarely set the hold bit so counting keeps going.
  // The flag tells whether the block does anything with the transaction.
  task automatic send_random(output bit counted);
    logic [1:0] act;
    logic [2:0] off;
    logic [7:0] wd;
    logic [7:0] tc;
    int         pick;
    pick = $urandom_range(0, 99);
    off  = 3'($urandom_range(0, 7));
    wd   = 8'($urandom_range(0, 255));
    tc   = 8'($urandom_range(0, 255));
    if (pick < 40) begin
      act = ActTick;
    end else if (pick < 62) begin
      act = ActRead;
    end else if (pick < 65) begin
      act = ActNone;
    end else begin
      act = ActWrite;
      if (off == OffStatus && $urandom_range(0, 3) != 0) begin
        wd[CtrlHoldBit] = 1'b0;
      end else if (off >= OffT1Msb && !off[0] && $urandom_range(0, 3) != 0) begin
        wd = 8'($urandom_range(0, 2));
      end
    end
    send_item(act, off, wd, tc);
    counted = (act != ActNone);
  endtask

  // Output side: before each result it draws a random stall, or none in no_idle phases.
  // Once, after enough items have gone in, it holds off for a long stretch
  // while the sender keeps offering, so the block fills and stalls its input.
  initial begin
    int  hold;
    bit  held_off;
    held_off = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held_off && sent_items >= HoldOffAfter) begin
        hold     = HoldOffCycles;
        held_off = 1'b1;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, MaxIdle);
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog: ends the run if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("three_channel_timer_module_core_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int  done_items;
    bit  counted;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Reads of untouched counters return the all-ones reset
    // value, and a zero tick leaves everything alone.
    send_item(ActRead, OffT1Msb, 8'h00, 8'h00);
    send_item(ActRead, OffT3Lsb, 8'hFF, 8'hFF);
    send_item(ActTick, OffStatus, 8'h00, 8'h00);
    // Control register 2 selects control register 1 for offset zero and
    // enables the timer 2 interrupt.
    send_item(ActWrite, OffCtrl2, 8'h41, 8'h00);
    send_item(ActWrite, OffStatus, 8'h40, 8'h00);
    // Timer 1 gets a latch of 3; the MSB write alone does not touch the
    // counter, the LSB write copies the latch across.
    send_item(ActWrite, OffT1Msb, 8'h00, 8'h00);
    send_item(ActRead, OffT1Msb, 8'h00, 8'h00);
    send_item(ActWrite, OffT1Lsb, 8'h03, 8'h00);
    // A full tick wraps timer 1 many times over in one transaction.
    send_item(ActTick, OffStatus, 8'h00, 8'hFF);
    send_item(ActRead, OffT1Lsb, 8'h00, 8'h00);
    // Status read returns the flags and clears them.
    send_item(ActRead, OffStatus, 8'h00, 8'h00);
    // Timer 2 with a latch of zero: a period of 65536 after the wrap.
    send_item(ActWrite, OffT2Msb, 8'h00, 8'h00);
    send_item(ActWrite, OffT2Lsb, 8'h00, 8'h00);
    send_item(ActTick, OffStatus, 8'h00, 8'h01);
    send_item(ActRead, OffT2Msb, 8'h00, 8'h00);
    // Offset zero now lands in control register 3.
    send_item(ActWrite, OffCtrl2, 8'h00, 8'h00);
    send_item(ActWrite, OffStatus, 8'hC0, 8'h00);
    send_item(ActWrite, OffT3Msb, 8'h01, 8'h00);
    send_item(ActWrite, OffT3Lsb, 8'h00, 8'h00);
    send_item(ActTick, OffStatus, 8'h00, 8'hFF);
    send_item(ActTick, OffStatus, 8'h00, 8'hFF);
    // Hold counting through control register 1, tick, then release it.
    send_item(ActWrite, OffCtrl2, 8'h01, 8'h00);
    send_item(ActWrite, OffStatus, 8'h01, 8'h00);
    send_item(ActTick, OffStatus, 8'h00, 8'hC8);
    send_item(ActNone, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    send_item(ActWrite, OffStatus, 8'h00, 8'h00);
    send_item(ActRead, OffCtrl2, 8'h00, 8'h00);

    // Random part, with phases of back-to-back traffic on both channels.
    done_items = 0;
    while (done_items < RandomItems) begin
      no_idle = ((done_items / 150) % 4) == 3;
      send_random(counted);
      if (counted) done_items++;
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (err_count == 0 && pending == 0) begin
      $display("three_channel_timer_module_core_tb: clean");
    end else begin
      $display("three_channel_timer_module_core_tb: errors");
    end
    $finish;
  end

endmodule
